@@ design/sbsfp_pkg.sv @@
// Shared types and constants for the servo bus status frame parser.
// No dependencies; imported by sbsfp_core and the top level.
package sbsfp_pkg;

    localparam int MAX_PARAMS_DEF = 64;
    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] LEN_OVERHEAD = 8'd2;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LEN_BAD = 2'd1,
        ST_CKS_BAD = 2'd2,
        ST_TIMEOUT = 2'd3
    } frame_status_t;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_HUNT1  = 8'b0000_0010,
        PH_HUNT2  = 8'b0000_0100,
        PH_ID     = 8'b0000_1000,
        PH_LEN    = 8'b0001_0000,
        PH_STAT   = 8'b0010_0000,
        PH_PARAMS = 8'b0100_0000,
        PH_CKS    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  byte_in;
        logic [15:0] timeout_ticks;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [5:0]  param_index;
        logic [7:0]  frame_id;
        logic [7:0]  raw_len;
        logic [7:0]  status_byte;
        logic [6:0]  param_total;
        logic [1:0]  status;
        logic        last;
    } result_t;

endpackage

@@ design/sbsfp_core.sv @@
// Frame state machine, checksum and timeout counter of the status parser.
// Depends on sbsfp_pkg; steps once per item presented with step high.
module sbsfp_core
    import sbsfp_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  in_item_t item,
    output logic     res_valid,
    output result_t  res
);

    localparam int CNT_W = $clog2(MAX_PARAMS + 1);

    phase_t           phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] expected_reg, expected_next;
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic [7:0]       id_reg, id_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       stat_reg, stat_next;
    logic [15:0]      time_reg, time_next;
    logic             len_bad_reg, len_bad_next;

    logic [7:0]       need;
    logic [CNT_W:0]   seen_inc;
    logic             emit;
    logic             emit_last;
    logic [1:0]       emit_status;
    logic [7:0]       emit_byte;
    logic [5:0]       emit_index;
    logic [7:0]       total_wide;
    logic [7:0]       index_wide;

    always_comb begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        expected_next = expected_reg;
        seen_next     = seen_reg;
        id_next       = id_reg;
        len_next      = len_reg;
        stat_next     = stat_reg;
        time_next     = time_reg;
        len_bad_next  = len_bad_reg;
        emit          = 1'b0;
        emit_last     = 1'b0;
        emit_status   = ST_OK;
        emit_byte     = 8'd0;
        emit_index    = 6'd0;
        index_wide    = 8'(seen_reg);
        need          = item.byte_in - LEN_OVERHEAD;
        seen_inc      = {1'b0, seen_reg} + (CNT_W+1)'(1);

        if (step) begin
            unique case (item.action)
                ACT_START: begin
                    sum_next      = '0;
                    expected_next = '0;
                    seen_next     = '0;
                    id_next       = '0;
                    len_next      = '0;
                    stat_next     = '0;
                    len_bad_next  = 1'b0;
                    time_next     = item.timeout_ticks;
                    phase_next    = PH_HUNT1;
                    if (item.timeout_ticks == 16'd0) begin
                        emit        = 1'b1;
                        emit_last   = 1'b1;
                        emit_status = ST_TIMEOUT;
                        phase_next  = PH_IDLE;
                    end
                end
                ACT_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        time_next = time_reg - 16'd1;
                        if (time_next == 16'd0) begin
                            emit        = 1'b1;
                            emit_last   = 1'b1;
                            emit_status = ST_TIMEOUT;
                            phase_next  = PH_IDLE;
                        end
                    end
                end
                ACT_BYTE: begin
                    unique case (phase_reg)
                        PH_IDLE: begin
                        end
                        PH_HUNT1: begin
                            phase_next = (item.byte_in == HDR_BYTE) ? PH_HUNT2 : PH_HUNT1;
                        end
                        PH_HUNT2: begin
                            phase_next = (item.byte_in == HDR_BYTE) ? PH_ID : PH_HUNT1;
                        end
                        PH_ID: begin
                            id_next    = item.byte_in;
                            sum_next   = item.byte_in;
                            phase_next = PH_LEN;
                        end
                        PH_LEN: begin
                            len_next = item.byte_in;
                            sum_next = sum_reg + item.byte_in;
                            if ({1'b0, need} > 9'(MAX_PARAMS)) begin
                                len_bad_next = 1'b1;
                                emit         = 1'b1;
                                emit_last    = 1'b1;
                                emit_status  = ST_LEN_BAD;
                                phase_next   = PH_IDLE;
                            end else begin
                                expected_next = need[CNT_W-1:0];
                                phase_next    = PH_STAT;
                            end
                        end
                        PH_STAT: begin
                            stat_next  = item.byte_in;
                            sum_next   = sum_reg + item.byte_in;
                            seen_next  = '0;
                            phase_next = (expected_reg == '0) ? PH_CKS : PH_PARAMS;
                        end
                        PH_PARAMS: begin
                            sum_next   = sum_reg + item.byte_in;
                            seen_next  = seen_inc[CNT_W-1:0];
                            if (seen_inc >= {1'b0, expected_reg}) begin
                                phase_next = PH_CKS;
                            end
                            emit       = 1'b1;
                            emit_byte  = item.byte_in;
                            emit_index = index_wide[5:0];
                        end
                        PH_CKS: begin
                            emit        = 1'b1;
                            emit_last   = 1'b1;
                            emit_status = (item.byte_in == ~sum_reg) ? ST_OK : ST_CKS_BAD;
                            phase_next  = PH_IDLE;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign total_wide = len_bad_next ? 8'd0 : 8'(expected_next);

    assign res_valid       = emit;
    assign res.kind        = emit_last;
    assign res.data_byte   = emit_byte;
    assign res.param_index = emit_index;
    assign res.frame_id    = id_next;
    assign res.raw_len     = len_next;
    assign res.status_byte = stat_next;
    assign res.param_total = total_wide[6:0];
    assign res.status      = emit_status;
    assign res.last        = emit_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            sum_reg      <= '0;
            expected_reg <= '0;
            seen_reg     <= '0;
            id_reg       <= '0;
            len_reg      <= '0;
            stat_reg     <= '0;
            time_reg     <= '0;
            len_bad_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            stat_reg     <= stat_next;
            time_reg     <= time_next;
            len_bad_reg  <= len_bad_next;
        end
    end

endmodule

@@ design/servo_bus_status_frame_parser_unit.sv @@
// Servo bus status frame parser: input register, parser core and result register.
// Depends on sbsfp_pkg and sbsfp_core.
//
// Usage:
//   The slave channel carries one transaction per event: s_tuser selects start
//   (load timeout, arm), received byte, or millisecond tick. A start arms the
//   parser; bytes are deframed (0xFF 0xFF, ID, LEN, status, parameters,
//   checksum). Each parameter byte gives one master transaction (tuser 0);
//   the frame ends with one status transaction (tuser 1, tlast 1): ok, bad
//   length, checksum mismatch or timeout. Ticks count the timeout down.
//   Once a frame ends, bytes and ticks are dropped until the next start.
// Timing:
//   One transaction per cycle sustained while m_tready stays high. An accepted
//   transaction sits in the input register, and its result is loaded into the
//   output register, which drives m_tvalid, once the output register can take it.
// Reset and stall:
//   aresetn low idles the parser and empties both registers. When m_tready
//   is low with a result pending, the pipeline holds; s_tready stays high
//   while the input register is empty, so one more transaction is taken.
module servo_bus_status_frame_parser_unit
    import sbsfp_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // byte_in, timeout_ticks
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // data_byte, param_index, frame_id,
                                              // raw_len, status_byte, param_total,
                                              // status, zero pad
    output logic                   m_tuser,   // kind
    output logic                   m_tlast    // last
);

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     m_valid_reg;
    result_t  m_res_reg;

    logic     out_ready;
    logic     step;
    logic     res_valid;
    result_t  res;

    assign out_ready = !m_valid_reg || m_tready;
    assign step      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action        <= s_tuser;
            in_item_reg.byte_in       <= s_tdata[7:0];
            in_item_reg.timeout_ticks <= s_tdata[23:8];
        end
    end

    sbsfp_core #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {1'b0, m_res_reg.status, m_res_reg.param_total,
                       m_res_reg.status_byte, m_res_reg.raw_len,
                       m_res_reg.frame_id, m_res_reg.param_index,
                       m_res_reg.data_byte};

    a_kind_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("result kind and last disagree");

    a_end_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[13:0] == 14'd0))
        else $error("end of frame result carries parameter data");

    a_param_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[46:45] == ST_OK))
        else $error("parameter result carries a nonzero status");

    a_result_follows_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid)) |-> $past(step && res_valid))
        else $error("result appeared without a parser step");

endmodule

@@ bench/tb_servo_bus_status_frame_parser_unit.sv @@
// Self-checking bench for servo_bus_status_frame_parser_unit: directed and random status frames.
// A scoreboard class predicts parameter and end-of-frame results for each accepted transaction.
// Depends on sbsfp_pkg and the parser RTL.
module tb_servo_bus_status_frame_parser_unit
    import sbsfp_pkg::*;
;

    localparam int          PARAM_LIMIT = MAX_PARAMS_DEF;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          RANDOM_ITEMS = 1100;

    class status_frame_scoreboard;
        phase_t      phase;
        logic [7:0]  sum;
        logic [7:0]  params_expected;
        logic [7:0]  params_seen;
        logic [7:0]  held_id;
        logic [7:0]  held_len;
        logic [7:0]  held_status;
        logic [15:0] time_left;
        logic        len_bad;
        result_t     expected_results[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_IDLE;
            sum = 8'd0;
            params_expected = 8'd0;
            params_seen = 8'd0;
            held_id = 8'd0;
            held_len = 8'd0;
            held_status = 8'd0;
            time_left = 16'd0;
            len_bad = 1'b0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void push_result(logic k, logic [7:0] d, logic [5:0] idx,
                                  frame_status_t st, logic lst);
            result_t r;
            r.kind = k;
            r.data_byte = d;
            r.param_index = idx;
            r.frame_id = held_id;
            r.raw_len = held_len;
            r.status_byte = held_status;
            r.param_total = len_bad ? 7'd0 : params_expected[6:0];
            r.status = st;
            r.last = lst;
            expected_results.push_back(r);
        endfunction

        function void end_frame(frame_status_t st);
            push_result(1'b1, 8'd0, 6'd0, st, 1'b1);
            phase = PH_IDLE;
        endfunction

        // Returns 1 unless the transaction is dropped without effect.
        function bit note_input(logic [1:0] act, logic [7:0] b, logic [15:0] ticks);
            logic [7:0] need;
            logic [7:0] cks;
            if (act == ACT_START) begin
                clear();
                time_left = ticks;
                phase = PH_HUNT1;
                if (ticks == 16'd0) end_frame(ST_TIMEOUT);
                return 1'b1;
            end
            if (phase == PH_IDLE) return 1'b0;
            if (act == ACT_TICK) begin
                time_left = time_left - 16'd1;
                if (time_left == 16'd0) end_frame(ST_TIMEOUT);
                return 1'b1;
            end
            if (act != ACT_BYTE) return 1'b0;
            case (phase)
                PH_HUNT1: begin
                    if (b == HDR_BYTE) phase = PH_HUNT2;
                end
                PH_HUNT2: begin
                    if (b == HDR_BYTE) phase = PH_ID;
                    else phase = PH_HUNT1;
                end
                PH_ID: begin
                    held_id = b;
                    sum = b;
                    phase = PH_LEN;
                end
                PH_LEN: begin
                    need = b - LEN_OVERHEAD;
                    held_len = b;
                    sum = sum + b;
                    if (need > PARAM_LIMIT) begin
                        len_bad = 1'b1;
                        end_frame(ST_LEN_BAD);
                    end else begin
                        params_expected = need;
                        phase = PH_STAT;
                    end
                end
                PH_STAT: begin
                    held_status = b;
                    sum = sum + b;
                    params_seen = 8'd0;
                    if (params_expected == 8'd0) phase = PH_CKS;
                    else phase = PH_PARAMS;
                end
                PH_PARAMS: begin
                    push_result(1'b0, b, params_seen[5:0], ST_OK, 1'b0);
                    sum = sum + b;
                    params_seen = params_seen + 8'd1;
                    if (params_seen >= params_expected) phase = PH_CKS;
                end
                PH_CKS: begin
                    cks = ~sum;
                    if (b == cks) end_frame(ST_OK);
                    else end_frame(ST_CKS_BAD);
                end
                default: phase = PH_IDLE;
            endcase
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: kind %0d status %0d",
                       got.kind, got.status);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("param_index", want.param_index, got.param_index);
            compare_field("frame_id", want.frame_id, got.frame_id);
            compare_field("raw_len", want.raw_len, got.raw_len);
            compare_field("status_byte", want.status_byte, got.status_byte);
            compare_field("param_total", want.param_total, got.param_total);
            compare_field("status", want.status, got.status);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    status_frame_scoreboard frame_board = new();

    int src_idle_pct = 30;
    int snk_idle_pct = 61;
    int effective_items = 0;
    int stall_requests = 0;
    int stall_served = 0;
    int hold_left = 0;
    int cycles = 0;

    servo_bus_status_frame_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge aclk) begin
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.data_byte = m_tdata[7:0];
            got.param_index = m_tdata[13:8];
            got.frame_id = m_tdata[21:14];
            got.raw_len = m_tdata[29:22];
            got.status_byte = m_tdata[37:30];
            got.param_total = m_tdata[44:38];
            got.status = m_tdata[46:45];
            got.last = m_tlast;
            frame_board.check_result(got);
        end
        if (hold_left == 0 && stall_served != stall_requests) begin
            stall_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic send_item(logic [1:0] act, logic [7:0] b, logic [15:0] ticks);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {ticks, b};
        do @(posedge aclk); while (!s_tready);
        if (frame_board.note_input(act, b, ticks)) effective_items++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(ACT_BYTE, b, 16'($urandom));
    endtask

    task automatic send_start(logic [15:0] ticks);
        send_item(ACT_START, 8'($urandom), ticks);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (frame_board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic directed_frames();
        send_byte(8'hFF);
        send_item(ACT_UNUSED, 8'hFF, 16'hFFFF);
        // rearm, drop the unused code, then restart with a zero timeout
        send_start(16'hFFFF);
        send_item(ACT_UNUSED, 8'h00, 16'h0000);
        send_start(16'h0000);
        // two parameters at the byte extremes, good checksum
        send_start(16'h8000);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFE);
        send_byte(8'h04);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFE);
        send_start(16'h0001);
        send_item(ACT_TICK, 8'h00, 16'h0000);
        // length one past the parameter limit
        send_start(16'd100);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h43);
        // no parameters, bad checksum
        send_start(16'd50);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h07);
        send_byte(8'h02);
        send_byte(8'h05);
        send_byte(8'h00);
    endtask

    task automatic random_frame();
        logic [7:0]  frame_q[$];
        logic [7:0]  id;
        logic [7:0]  len;
        logic [7:0]  stat;
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] ticks;
        int          need;
        int          cut;
        int          tick_pct;
        int          roll;
        roll = $urandom_range(99);
        tick_pct = 3;
        if (roll < 8) begin
            ticks = 16'($urandom_range(1, 6));
            tick_pct = 30;
        end else if (roll < 10) begin
            ticks = 16'd0;
        end else begin
            ticks = 16'($urandom_range(256, 65535));
        end
        send_start(ticks);

        repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom_range(0, 254)));
        if ($urandom_range(9) == 0) begin
            frame_q.push_back(HDR_BYTE);
            frame_q.push_back(8'($urandom_range(0, 254)));
        end
        frame_q.push_back(HDR_BYTE);
        frame_q.push_back(HDR_BYTE);
        id = 8'($urandom);
        frame_q.push_back(id);
        if ($urandom_range(99) < 85) begin
            if ($urandom_range(9) < 8) need = $urandom_range(0, 8);
            else need = $urandom_range(9, PARAM_LIMIT);
            len = 8'(need + 2);
        end else begin
            need = -1;
            if ($urandom_range(1) == 1) len = 8'($urandom_range(0, 1));
            else len = 8'($urandom_range(PARAM_LIMIT + 3, 255));
        end
        frame_q.push_back(len);
        if (need >= 0) begin
            stat = 8'($urandom);
            frame_q.push_back(stat);
            sum = id + len + stat;
            for (int i = 0; i < need; i++) begin
                b = 8'($urandom);
                frame_q.push_back(b);
                sum = sum + b;
            end
            if ($urandom_range(99) < 85) frame_q.push_back(~sum);
            else frame_q.push_back(8'($urandom));
        end

        if ($urandom_range(99) < 8) cut = $urandom_range(1, frame_q.size());
        else cut = frame_q.size();
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(99) < tick_pct) send_item(ACT_TICK, 8'($urandom), 16'($urandom));
            if ($urandom_range(99) == 0) send_item(ACT_UNUSED, 8'($urandom), 16'($urandom));
            send_byte(frame_q[i]);
        end
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3))
                send_item(2'($urandom_range(1, 3)), 8'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        int src_pct[3];
        int snk_pct[3];
        int target;
        src_pct = '{30, 61, 0};
        snk_pct = '{61, 30, 0};
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_frames();
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            src_idle_pct = src_pct[p];
            snk_idle_pct = snk_pct[p];
            target = effective_items + RANDOM_ITEMS / 3;
            while (effective_items < target) begin
                random_frame();
                if (p == 0 && stall_requests == 0 && effective_items > target - 200)
                    stall_requests++;
                if (p == 1 && effective_items > target - 150 && effective_items < target - 100)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (frame_board.errors == 0 && frame_board.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/sbsfp_pkg.sv
design/sbsfp_core.sv
design/servo_bus_status_frame_parser_unit.sv
bench/tb_servo_bus_status_frame_parser_unit.sv
